@@ src/lrubb_pkg.sv @@
package lrubb_pkg;

   localparam int KEY_W    = 24;
   localparam int TAG_W    = 16;
   localparam int BUDGET_W = 16;
   localparam int ACC_W    = 32;
   localparam int BYTES_W  = 36;
   localparam int COST_W   = 27;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd1024;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_GET    = 2'd1,
      KIND_EVICT  = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_TOO_BIG  = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_RSVD     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SCAN_TAG    = 2'd0,
      SCAN_OLDEST = 2'd1,
      SCAN_FREE   = 2'd2,
      SCAN_NONE   = 2'd3
   } scan_mode_type;

   typedef struct packed {
      logic          ready;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          remove;
      logic          write;
      logic          get_upd;
      logic          emit;
      logic          emit_notice;
      status_type    emit_status;
      logic          emit_hit;
   } cmd_type;

   typedef struct packed {
      logic     req_fire;
      kind_type kind;
      logic     scan_done;
      logic     found;
      logic     out_free;
      logic     too_big;
      logic     over_budget;
      logic     empty;
      logic     full;
   } stat_type;

endpackage

@@ src/lrubb_if.sv @@
interface lrubb_req_if;
   import lrubb_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [TAG_W-1:0]  tag;
   logic [KEY_W-1:0]  key_len;
   logic [KEY_W-1:0]  value_len;
   modport source (output valid, kind, tag, key_len, value_len, input ready);
   modport sink (input valid, kind, tag, key_len, value_len, output ready);
endinterface

interface lrubb_rsp_if;
   import lrubb_pkg::*;
   logic               valid;
   logic               ready;
   logic               is_notice;
   logic               last;
   logic [TAG_W-1:0]   tag_out;
   logic [1:0]         status;
   logic [KEY_W-1:0]   key_len_out;
   logic [KEY_W-1:0]   value_len_out;
   logic [ACC_W-1:0]   access_count_out;
   logic [BYTES_W-1:0] used_bytes;
   modport source (output valid, is_notice, last, tag_out, status, key_len_out,
                   value_len_out, access_count_out, used_bytes, input ready);
   modport sink (input valid, is_notice, last, tag_out, status, key_len_out,
                 value_len_out, access_count_out, used_bytes, output ready);
endinterface

@@ src/lrubb_ctrl.sv @@
module lrubb_ctrl
   import lrubb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_INS_CHK, S_BUD_SCAN, S_BUD_REM, S_BUD_NOTE, S_INS_TAG, S_REPL_REM,
      S_FULL_SCAN, S_FULL_REM, S_FULL_NOTE, S_FREE_SCAN, S_WRITE, S_GET_SCAN,
      S_GET_UPD, S_EV_SCAN, S_FINAL
   } state_type;

   state_type  state_ff, state_in;
   status_type fstat_ff, fstat_in;
   logic       hit_ff, hit_in;
   logic       ev_ff, ev_in;

   always_comb begin
      state_in = state_ff;
      fstat_in = fstat_ff;
      hit_in   = hit_ff;
      ev_in    = ev_ff;
      cmd = '0;
      cmd.scan_mode   = SCAN_NONE;
      cmd.emit_status = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_fire) begin
               fstat_in = STAT_OK;
               hit_in   = 1'b0;
               ev_in    = 1'b0;
               unique case (stat.kind)
                  KIND_INSERT: state_in = S_INS_CHK;
                  KIND_GET: begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode  = SCAN_TAG;
                     state_in = S_GET_SCAN;
                  end
                  KIND_EVICT: begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode  = SCAN_TAG;
                     state_in = S_EV_SCAN;
                  end
                  KIND_NOP: state_in = S_FINAL;
               endcase
            end
         end
         S_INS_CHK: begin
            priority if (stat.too_big) begin
               fstat_in = STAT_TOO_BIG;
               state_in = S_FINAL;
            end else if (stat.over_budget && !stat.empty) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_OLDEST;
               state_in = S_BUD_SCAN;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_TAG;
               state_in = S_INS_TAG;
            end
         end
         S_BUD_SCAN: if (stat.scan_done) state_in = S_BUD_REM;
         S_BUD_REM: begin
            cmd.remove = 1'b1;
            state_in = S_BUD_NOTE;
         end
         S_BUD_NOTE: if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.emit_notice = 1'b1;
            state_in = S_INS_CHK;
         end
         S_INS_TAG: if (stat.scan_done) begin
            priority if (stat.found) state_in = S_REPL_REM;
            else if (stat.full) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_OLDEST;
               state_in = S_FULL_SCAN;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_FREE;
               state_in = S_FREE_SCAN;
            end
         end
         S_REPL_REM: begin
            cmd.remove = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_FREE;
            state_in = S_FREE_SCAN;
         end
         S_FULL_SCAN: if (stat.scan_done) state_in = S_FULL_REM;
         S_FULL_REM: begin
            cmd.remove = 1'b1;
            state_in = S_FULL_NOTE;
         end
         S_FULL_NOTE: if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.emit_notice = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_FREE;
            state_in = S_FREE_SCAN;
         end
         S_FREE_SCAN: if (stat.scan_done) state_in = S_WRITE;
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in = S_FINAL;
         end
         S_GET_SCAN: if (stat.scan_done) begin
            if (stat.found) state_in = S_GET_UPD;
            else begin
               fstat_in = STAT_NOT_FOUND;
               state_in = S_FINAL;
            end
         end
         S_GET_UPD: begin
            cmd.get_upd = 1'b1;
            hit_in = 1'b1;
            state_in = S_FINAL;
         end
         S_EV_SCAN: begin
            if (ev_ff) begin
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.emit_notice = 1'b1;
                  state_in = S_FINAL;
               end
            end else if (stat.scan_done) begin
               if (stat.found) begin
                  cmd.remove = 1'b1;
                  ev_in = 1'b1;
               end else begin
                  fstat_in = STAT_NOT_FOUND;
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: if (stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.emit_status = fstat_ff;
            cmd.emit_hit = hit_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fstat_ff <= STAT_OK;
         hit_ff   <= 1'b0;
         ev_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fstat_ff <= fstat_in;
         hit_ff   <= hit_in;
         ev_ff    <= ev_in;
      end
   end

endmodule

@@ src/lrubb_dp.sv @@
module lrubb_dp
   import lrubb_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data,
   lrubb_req_if.sink           req_bus,
   lrubb_rsp_if.source         rsp_bus,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [BUDGET_W-1:0] budget_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [KEY_W-1:0]    kl_ff, vl_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [CW-1:0]       count_ff;

   logic                valid_ff [ENTRIES];
   logic [TAG_W-1:0]    stag_ff  [ENTRIES];
   logic [KEY_W-1:0]    skl_ff   [ENTRIES];
   logic [KEY_W-1:0]    svl_ff   [ENTRIES];
   logic [ACC_W-1:0]    sacc_ff  [ENTRIES];
   logic [IW-1:0]       rank_ff  [ENTRIES];

   logic                scanning_ff, done_ff, found_ff;
   scan_mode_type       mode_ff;
   logic [IW-1:0]       idx_ff, sel_ff, sel_rank_ff;
   logic [TAG_W-1:0]    victim_ff;

   logic                rsp_valid_ff;
   logic                fire, out_free, scan_hit;
   logic [COST_W-1:0]   cost, sel_cost;
   logic [BYTES_W-1:0]  budget;
   logic [IW-1:0]       oldest_rank;

   assign fire     = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cost     = ({3'b0, kl_ff} + {3'b0, vl_ff}) << 2;
   assign sel_cost = ({3'b0, skl_ff[sel_ff]} + {3'b0, svl_ff[sel_ff]}) << 2;
   assign budget   = {budget_ff, 20'b0};
   assign oldest_rank = IW'(count_ff - CW'(1));

   always_comb begin
      unique case (mode_ff)
         SCAN_TAG:    scan_hit = valid_ff[idx_ff] && stag_ff[idx_ff] == tag_ff;
         SCAN_OLDEST: scan_hit = valid_ff[idx_ff] && rank_ff[idx_ff] == oldest_rank;
         SCAN_FREE:   scan_hit = !valid_ff[idx_ff];
         default:     scan_hit = 1'b0;
      endcase
   end

   assign req_bus.ready = cmd.ready;

   always_comb begin
      stat.req_fire    = fire;
      stat.kind        = kind_type'(req_bus.kind);
      stat.scan_done   = done_ff;
      stat.found       = found_ff;
      stat.out_free    = out_free;
      stat.too_big     = {9'b0, cost} > budget;
      stat.over_budget = ({1'b0, bytes_ff} + {10'b0, cost}) > {1'b0, budget};
      stat.empty       = count_ff == '0;
      stat.full        = count_ff == CW'(ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_wr_en) begin
         budget_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tag_ff    <= req_bus.tag;
         kl_ff     <= req_bus.key_len;
         vl_ff     <= req_bus.value_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
         mode_ff     <= SCAN_NONE;
         idx_ff      <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.scan_start) begin
            scanning_ff <= 1'b1;
            mode_ff     <= cmd.scan_mode;
            idx_ff      <= '0;
         end else if (scanning_ff) begin
            if (scan_hit) begin
               scanning_ff <= 1'b0;
               done_ff     <= 1'b1;
               found_ff    <= 1'b1;
            end else if (idx_ff == IW'(ENTRIES - 1)) begin
               scanning_ff <= 1'b0;
               done_ff     <= 1'b1;
               found_ff    <= 1'b0;
            end else begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scanning_ff && scan_hit) begin
         sel_ff      <= idx_ff;
         sel_rank_ff <= rank_ff[idx_ff];
      end
      if (cmd.remove) begin
         victim_ff <= stag_ff[sel_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (cmd.remove) begin
            bytes_ff <= (bytes_ff >= {9'b0, sel_cost}) ? bytes_ff - {9'b0, sel_cost} : '0;
            count_ff <= count_ff - CW'(1);
            valid_ff[sel_ff] <= 1'b0;
         end else if (cmd.write) begin
            bytes_ff <= bytes_ff + {9'b0, cost};
            count_ff <= count_ff + CW'(1);
            valid_ff[sel_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.remove) begin
            if (valid_ff[i] && rank_ff[i] > sel_rank_ff) rank_ff[i] <= rank_ff[i] - IW'(1);
         end else if (cmd.write) begin
            if (IW'(i) == sel_ff) rank_ff[i] <= '0;
            else if (valid_ff[i]) rank_ff[i] <= rank_ff[i] + IW'(1);
         end else if (cmd.get_upd) begin
            if (IW'(i) == sel_ff) rank_ff[i] <= '0;
            else if (valid_ff[i] && rank_ff[i] < sel_rank_ff) rank_ff[i] <= rank_ff[i] + IW'(1);
         end
      end
      if (cmd.write) begin
         stag_ff[sel_ff] <= tag_ff;
         skl_ff[sel_ff]  <= kl_ff;
         svl_ff[sel_ff]  <= vl_ff;
         sacc_ff[sel_ff] <= '0;
      end else if (cmd.get_upd && sacc_ff[sel_ff] != '1) begin
         sacc_ff[sel_ff] <= sacc_ff[sel_ff] + ACC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_bus.is_notice        <= cmd.emit_notice;
         rsp_bus.last             <= !cmd.emit_notice;
         rsp_bus.tag_out          <= cmd.emit_notice ? victim_ff : tag_ff;
         rsp_bus.status           <= cmd.emit_status;
         rsp_bus.key_len_out      <= cmd.emit_hit ? skl_ff[sel_ff] : '0;
         rsp_bus.value_len_out    <= cmd.emit_hit ? svl_ff[sel_ff] : '0;
         rsp_bus.access_count_out <= cmd.emit_hit ? sacc_ff[sel_ff] : '0;
         rsp_bus.used_bytes       <= bytes_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule

@@ src/lru_byte_budget_cache_directory.sv @@
// LRU directory of cache entries under a byte budget (csr_wr_data in MiB, reset 1024).
// Each request beat yields one or more response beats: eviction notices
// first, then one final beat with last set. Work is done by a controller
// that walks the slot table one slot per cycle in each tag, oldest or free
// slot search. A request beat is taken only while the controller is idle;
// a finished response may still wait in the output register.
module lru_byte_budget_cache_directory
   import lrubb_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data,
   lrubb_req_if.sink           req_bus,
   lrubb_rsp_if.source         rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   lrubb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   lrubb_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .cmd         (cmd),
      .stat        (stat)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request beat taken while busy");

   a_notice_xor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.is_notice != rsp_bus.last)
      else $error("notice and last both set or both clear");

   a_notice_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_notice |-> rsp_bus.status == STAT_OK)
      else $error("notice carries error status");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response register overwritten");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   import lrubb_pkg::*;

   localparam int SLOTS = 16;
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic             is_notice;
      logic             last;
      logic [TAG_W-1:0] tag_out;
      status_type       status;
      logic [KEY_W-1:0] key_len_out;
      logic [KEY_W-1:0] value_len_out;
      logic [ACC_W-1:0] access_count_out;
      logic [BYTES_W-1:0] used_bytes;
   } dir_beat_type;

   class budget_lru_scoreboard;
      bit                 slot_used[SLOTS];
      logic [TAG_W-1:0]   slot_tag[SLOTS];
      logic [KEY_W-1:0]   slot_klen[SLOTS];
      logic [KEY_W-1:0]   slot_vlen[SLOTS];
      logic [ACC_W-1:0]   slot_hits[SLOTS];
      int                 slot_age[SLOTS];
      longint unsigned    bytes_held;
      logic [BUDGET_W-1:0] budget_mb;
      dir_beat_type       pending_q[$];
      int                 errors;

      function void clear();
         foreach (slot_used[i]) begin
            slot_used[i] = 0;
            slot_age[i] = 0;
         end
         bytes_held = 0;
         budget_mb = BUDGET_RESET;
         errors = 0;
      endfunction

      function longint unsigned cost_of(int s);
         return (longint'(slot_klen[s]) + longint'(slot_vlen[s])) * 4;
      endfunction

      function int lookup(logic [TAG_W-1:0] t);
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_tag[i] == t) return i;
         return -1;
      endfunction

      function int oldest();
         int best;
         best = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
         return best;
      endfunction

      function int free_slot();
         for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i]) return i;
         return -1;
      endfunction

      function void push(logic n, logic l, logic [TAG_W-1:0] t, status_type st,
                         logic [KEY_W-1:0] kl, logic [KEY_W-1:0] vl, logic [ACC_W-1:0] ac);
         dir_beat_type b;
         b.is_notice = n;
         b.last = l;
         b.tag_out = t;
         b.status = st;
         b.key_len_out = kl;
         b.value_len_out = vl;
         b.access_count_out = ac;
         b.used_bytes = bytes_held[BYTES_W-1:0];
         pending_q.push_back(b);
      endfunction

      function void drop_slot(int s);
         longint unsigned c;
         c = cost_of(s);
         bytes_held = (bytes_held >= c) ? bytes_held - c : 0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] > slot_age[s]) slot_age[i]--;
         slot_used[s] = 0;
      endfunction

      function void evict_notice(int s);
         logic [TAG_W-1:0] t;
         t = slot_tag[s];
         drop_slot(s);
         push(1, 0, t, STAT_OK, 0, 0, 0);
      endfunction

      function void note_request(kind_type kind, logic [TAG_W-1:0] t,
                                 logic [KEY_W-1:0] kl, logic [KEY_W-1:0] vl);
         longint unsigned cost, limit;
         int s;
         limit = longint'(budget_mb) << 20;
         case (kind)
            KIND_INSERT: begin
               cost = (longint'(kl) + longint'(vl)) * 4;
               if (cost > limit) begin
                  push(0, 1, t, STAT_TOO_BIG, 0, 0, 0);
                  return;
               end
               while (bytes_held + cost > limit && oldest() >= 0) evict_notice(oldest());
               s = lookup(t);
               if (s >= 0) begin
                  drop_slot(s);
               end else begin
                  s = free_slot();
                  if (s < 0) begin
                     evict_notice(oldest());
                     s = free_slot();
                  end
               end
               for (int i = 0; i < SLOTS; i++)
                  if (slot_used[i]) slot_age[i]++;
               slot_used[s] = 1;
               slot_tag[s] = t;
               slot_klen[s] = kl;
               slot_vlen[s] = vl;
               slot_hits[s] = 0;
               slot_age[s] = 0;
               bytes_held = (bytes_held + cost) & 64'hF_FFFF_FFFF;
               push(0, 1, t, STAT_OK, 0, 0, 0);
            end
            KIND_GET: begin
               s = lookup(t);
               if (s < 0) begin
                  push(0, 1, t, STAT_NOT_FOUND, 0, 0, 0);
                  return;
               end
               if (slot_hits[s] != '1) slot_hits[s]++;
               for (int i = 0; i < SLOTS; i++)
                  if (i != s && slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
               slot_age[s] = 0;
               push(0, 1, t, STAT_OK, slot_klen[s], slot_vlen[s], slot_hits[s]);
            end
            KIND_EVICT: begin
               s = lookup(t);
               if (s < 0) begin
                  push(0, 1, t, STAT_NOT_FOUND, 0, 0, 0);
                  return;
               end
               evict_notice(s);
               push(0, 1, t, STAT_OK, 0, 0, 0);
            end
            default: push(0, 1, t, STAT_OK, 0, 0, 0);
         endcase
      endfunction

      function void check_result(dir_beat_type a);
         dir_beat_type e;
         if (pending_q.size() == 0) begin
            $error("unexpected response beat, tag_out %0h", a.tag_out);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (a.is_notice !== e.is_notice) begin
            $error("is_notice: expected %0h actual %0h", e.is_notice, a.is_notice);
            errors++;
         end
         if (a.last !== e.last) begin
            $error("last: expected %0h actual %0h", e.last, a.last);
            errors++;
         end
         if (a.tag_out !== e.tag_out) begin
            $error("tag_out: expected %0h actual %0h", e.tag_out, a.tag_out);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0h actual %0h", e.status, a.status);
            errors++;
         end
         if (a.key_len_out !== e.key_len_out) begin
            $error("key_len_out: expected %0h actual %0h", e.key_len_out, a.key_len_out);
            errors++;
         end
         if (a.value_len_out !== e.value_len_out) begin
            $error("value_len_out: expected %0h actual %0h", e.value_len_out,
                   a.value_len_out);
            errors++;
         end
         if (a.access_count_out !== e.access_count_out) begin
            $error("access_count_out: expected %0h actual %0h", e.access_count_out,
                   a.access_count_out);
            errors++;
         end
         if (a.used_bytes !== e.used_bytes) begin
            $error("used_bytes: expected %0h actual %0h", e.used_bytes, a.used_bytes);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [BUDGET_W-1:0] csr_wr_data = '0;

   lrubb_req_if req_bus ();
   lrubb_rsp_if rsp_bus ();

   lru_byte_budget_cache_directory u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus.sink),
      .rsp_bus    (rsp_bus.source)
   );

   budget_lru_scoreboard dir_model = new();
   int unsigned req_taken = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_phase = 0;
   logic [7:0] ready_pattern = 8'hFF;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.kind = KIND_NOP;
      req_bus.tag = '0;
      req_bus.key_len = '0;
      req_bus.value_len = '0;
      rsp_bus.ready = 0;
      dir_model.clear();
   end

   always @(posedge clock) begin
      dir_beat_type b;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            dir_model.note_request(kind_type'(req_bus.kind), req_bus.tag,
                                   req_bus.key_len, req_bus.value_len);
            req_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            b.is_notice = rsp_bus.is_notice;
            b.last = rsp_bus.last;
            b.tag_out = rsp_bus.tag_out;
            b.status = status_type'(rsp_bus.status);
            b.key_len_out = rsp_bus.key_len_out;
            b.value_len_out = rsp_bus.value_len_out;
            b.access_count_out = rsp_bus.access_count_out;
            b.used_bytes = rsp_bus.used_bytes;
            dir_model.check_result(b);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 97 == 0)
         ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      rsp_bus.ready = reset ? 1'b0 : ready_pattern[stall_phase % 8];
   end

   task automatic send_req(kind_type k, logic [TAG_W-1:0] t,
                           logic [KEY_W-1:0] kl, logic [KEY_W-1:0] vl);
      int unsigned seen;
      seen = req_taken;
      req_bus.kind = k;
      req_bus.tag = t;
      req_bus.key_len = kl;
      req_bus.value_len = vl;
      req_bus.valid = 1;
      do @(negedge clock); while (req_taken == seen);
   endtask

   task automatic idle_gap(int n);
      req_bus.valid = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_then_write(logic [BUDGET_W-1:0] mb);
      req_bus.valid = 0;
      while (dir_model.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_data = mb;
      csr_wr_en = 1;
      @(negedge clock);
      csr_wr_en = 0;
      dir_model.budget_mb = mb;
   endtask

   task automatic random_burst(int count, logic [BUDGET_W-1:0] mb);
      kind_type k;
      logic [TAG_W-1:0] t;
      logic [KEY_W-1:0] kl, vl;
      int unsigned span, pick, done;
      span = (mb == 0) ? 3 : ((longint'(mb) * 262144) / 6 > 16777215 ? 16777215
                              : int'((longint'(mb) * 262144) / 6));
      done = 0;
      while (done < count) begin
         for (int j = $urandom_range(1, 8); j > 0 && done < count; j--) begin
            pick = $urandom_range(0, 99);
            k = pick < 45 ? KIND_INSERT : pick < 75 ? KIND_GET : pick < 90 ? KIND_EVICT
                                                                : KIND_NOP;
            t = ($urandom_range(0, 99) < 85) ? TAG_W'($urandom_range(0, 23)) : TAG_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               kl = KEY_W'($urandom_range(0, span));
               vl = KEY_W'($urandom_range(0, span));
            end else if (pick < 85) begin
               kl = KEY_W'($urandom);
               vl = KEY_W'($urandom);
            end else begin
               kl = 0;
               vl = KEY_W'($urandom_range(0, 3));
            end
            send_req(k, t, kl, vl);
            done++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      req_bus.valid = 0;
   endtask

   initial begin
      logic [BUDGET_W-1:0] budgets[6];
      budgets = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd1024, 16'd2};
      budgets[4] = BUDGET_W'($urandom_range(4, 2000));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_req(KIND_INSERT, 16'h0000, '0, '0);
      send_req(KIND_INSERT, 16'h0001, '1, '1);
      send_req(KIND_GET, 16'h0000, '0, '0);
      send_req(KIND_GET, 16'h0001, '0, '0);
      send_req(KIND_GET, 16'hFFFF, '0, '0);
      send_req(KIND_EVICT, 16'h0000, '0, '0);
      send_req(KIND_EVICT, 16'h0000, '0, '0);
      send_req(KIND_NOP, 16'hFFFF, '1, '1);
      send_req(KIND_INSERT, 16'h0001, 24'd5, 24'd7);
      for (int i = 0; i < 17; i++) send_req(KIND_INSERT, TAG_W'(16'h100 + i), 24'd1, 24'd1);

      drain_then_write(16'd1);
      send_req(KIND_INSERT, 16'h0002, 24'd262144, 24'd1);
      for (int i = 0; i < 5; i++) send_req(KIND_INSERT, TAG_W'(i), 24'd60000, 24'd40000);
      send_req(KIND_INSERT, 16'h0003, 24'd200000, 24'd62144);

      foreach (budgets[p]) begin
         drain_then_write(budgets[p]);
         random_burst(56, budgets[p]);
      end

      while (dir_model.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (dir_model.errors == 0 && dir_model.pending_q.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
